### sv/atte_pkg.sv
package atte_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic [1:0] CFG_NUM_COLS   = 2'd0;
  localparam logic [1:0] CFG_NUM_ROWS   = 2'd1;
  localparam logic [1:0] CFG_SERIAL_OUT = 2'd2;

  localparam logic [2:0] CMD_PRINT  = 3'd0;
  localparam logic [2:0] CMD_SCROLL = 3'd1;
  localparam logic [2:0] CMD_MOVE   = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_BG     = 3'd4;
  localparam logic [2:0] CMD_FG     = 3'd5;
  localparam logic [2:0] CMD_SERIAL = 3'd6;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_ESC = 8'h1B;

  localparam logic [9:0]  BG_BASE     = 10'd40;
  localparam logic [9:0]  FG_BASE     = 10'd30;
  localparam logic [10:0] COLOR_BLACK = 11'd0;
  localparam logic [10:0] COLOR_WHITE = 11'd7;

  typedef enum logic [2:0] {
    K_OTHER = 3'd0,
    K_DIGIT = 3'd1,
    K_SEMI  = 3'd2,
    K_NL    = 3'd3,
    K_TAB   = 3'd4,
    K_BS    = 3'd5,
    K_ESC   = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } fe_item_t;

  typedef struct packed {
    logic [7:0] num_cols;
    logic [7:0] num_rows;
    logic       serial_out;
  } cfg_t;

  typedef struct packed {
    logic [10:0] arg;
    logic [7:0]  pos_row;
    logic [7:0]  pos_col;
    logic [7:0]  glyph;
    logic [2:0]  cmd;
  } out_item_t;

endpackage

### sv/atte_front.sv
module atte_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data,
  output logic                q_valid,
  input  logic                q_pop,
  output atte_pkg::fe_item_t  q_item
);

  localparam int PW = $clog2(atte_pkg::FIFO_DEPTH);

  atte_pkg::fe_item_t mem [atte_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  atte_pkg::kind_t kind;
  logic push, pop;

  // Classify the byte on the way in so the back end decodes less.
  always_comb begin
    kind = atte_pkg::K_OTHER;
    if (in_data >= 8'h30 && in_data <= 8'h39) begin
      kind = atte_pkg::K_DIGIT;
    end else if (in_data == 8'h3B) begin
      kind = atte_pkg::K_SEMI;
    end else if (in_data == atte_pkg::CH_LF || in_data == atte_pkg::CH_CR) begin
      kind = atte_pkg::K_NL;
    end else if (in_data == atte_pkg::CH_TAB) begin
      kind = atte_pkg::K_TAB;
    end else if (in_data == atte_pkg::CH_BS) begin
      kind = atte_pkg::K_BS;
    end else if (in_data == atte_pkg::CH_ESC) begin
      kind = atte_pkg::K_ESC;
    end
  end

  assign in_ready = (count != (PW+1)'(atte_pkg::FIFO_DEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{kind: kind, data: in_data};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/atte_back.sv
module atte_back #(
  parameter int MAX_PARAMS = 16,
  parameter int TAB_STEP   = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  atte_pkg::cfg_t      cfg,
  input  logic                q_valid,
  output logic                q_pop,
  input  atte_pkg::fe_item_t  q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output atte_pkg::out_item_t out_item,
  output logic                out_last
);

  localparam int PCW = $clog2(MAX_PARAMS);
  localparam int RECIP = (65536 + TAB_STEP - 1) / TAB_STEP;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SER  = 7'b0000010,
    S_TAB  = 7'b0000100,
    S_WALK = 7'b0001000,
    S_J    = 7'b0010000,
    S_POST = 7'b0100000,
    S_MOVE = 7'b1000000
  } state_t;

  typedef enum logic [4:0] {
    P_IDLE = 5'b00001,
    P_ESC  = 5'b00010,
    P_CSI  = 5'b00100,
    P_NUM  = 5'b01000,
    P_SEMI = 5'b10000
  } pstate_t;

  state_t  state, state_next;
  pstate_t pstate, pstate_next;
  logic signed [12:0] col, col_next, row, row_next;
  logic [PCW-1:0] pcnt, pcnt_next, widx, widx_next;
  logic [1:0]  dcnt, dcnt_next;
  logic [9:0]  cur, cur_next;
  logic [9:0]  store [MAX_PARAMS];
  logic        st_we;
  logic [PCW-1:0] st_wa;
  logic [9:0]  st_wd;
  logic        sub, sub_next;
  logic [7:0]  chr, chr_next;
  logic [7:0]  tab_q, tab_q_next;

  logic        can_emit, emit, e_last;
  atte_pkg::out_item_t e_item;

  logic [8:0]  cols_eff, rows_eff;
  logic signed [12:0] cols_s, rows_s, cnt_s, c1, r1, tab_col;
  logic [9:0]  p0, p1, cnt, wval, dig;
  logic [24:0] tab_prod;
  logic [7:0]  byte_c;
  logic        is_digit, do_fin;

  assign cols_eff = (cfg.num_cols == 8'd0) ? 9'd1 : {1'b0, cfg.num_cols};
  assign rows_eff = (cfg.num_rows == 8'd0) ? 9'd1 : {1'b0, cfg.num_rows};
  assign cols_s   = signed'({4'b0, cols_eff});
  assign rows_s   = signed'({4'b0, rows_eff});
  assign p0       = (pcnt != '0) ? store[0] : 10'd0;
  assign p1       = (pcnt > PCW'(1)) ? store[1] : 10'd0;
  assign cnt      = (p0 == 10'd0) ? 10'd1 : p0;
  assign cnt_s    = signed'({3'b0, cnt});
  assign wval     = store[widx];
  assign byte_c   = q_item.data;
  assign is_digit = (q_item.kind == atte_pkg::K_DIGIT);
  assign dig      = {6'b0, byte_c[3:0]};
  assign can_emit = !out_valid || out_ready;
  assign tab_prod = {17'b0, col[7:0]} * 25'(RECIP);
  assign tab_col  = signed'(13'((tab_q + 9'd1) * TAB_STEP));

  always_comb begin
    c1 = (col < 0) ? 13'sd0 : col;
    if (c1 > cols_s - 13'sd1) c1 = cols_s - 13'sd1;
    r1 = (row < 0) ? 13'sd0 : row;
  end

  always_comb begin
    state_next  = state;
    pstate_next = pstate;
    col_next    = col;
    row_next    = row;
    pcnt_next   = pcnt;
    widx_next   = widx;
    dcnt_next   = dcnt;
    cur_next    = cur;
    sub_next    = sub;
    chr_next    = chr;
    tab_q_next  = tab_prod[23:16];
    st_we       = 1'b0;
    st_wa       = pcnt;
    st_wd       = dig;
    q_pop       = 1'b0;
    emit        = 1'b0;
    e_last      = 1'b0;
    e_item      = '0;
    do_fin      = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid && can_emit) begin
          q_pop    = 1'b1;
          chr_next = byte_c;
          if (cfg.serial_out) begin
            state_next = S_SER;
            if (byte_c == atte_pkg::CH_LF) begin
              emit         = 1'b1;
              e_item.cmd   = atte_pkg::CMD_SERIAL;
              e_item.glyph = atte_pkg::CH_CR;
            end
          end else begin
            state_next = S_POST;
            case (pstate)
              P_ESC: begin
                pstate_next = P_IDLE;
                if (byte_c == "D") begin
                  row_next = row + 13'sd1;
                end else if (byte_c == "M") begin
                  if (row > 0) row_next = row - 13'sd1;
                end else if (byte_c == "H") begin
                  state_next = S_TAB;
                end else if (byte_c == "[") begin
                  pstate_next = P_CSI;
                end
              end
              P_CSI, P_SEMI: begin
                if (is_digit) begin
                  pstate_next = P_NUM;
                  if (32'(pcnt) < MAX_PARAMS - 1) begin
                    st_we     = 1'b1;
                    cur_next  = dig;
                    pcnt_next = pcnt + 1'b1;
                    dcnt_next = 2'd1;
                  end else begin
                    dcnt_next = 2'd3;
                  end
                end else if (pstate == P_SEMI) begin
                  pstate_next = P_IDLE;
                end else begin
                  do_fin = 1'b1;
                end
              end
              P_NUM: begin
                if (q_item.kind == atte_pkg::K_SEMI) begin
                  pstate_next = P_SEMI;
                end else if (is_digit) begin
                  if (dcnt < 2'd3 && pcnt != '0) begin
                    st_we     = 1'b1;
                    st_wa     = pcnt - 1'b1;
                    st_wd     = 10'((cur << 3) + (cur << 1) + dig);
                    cur_next  = st_wd;
                    dcnt_next = dcnt + 2'd1;
                  end
                end else begin
                  do_fin = 1'b1;
                end
              end
              default: begin
                pstate_next = P_IDLE;
                case (q_item.kind)
                  atte_pkg::K_NL: begin
                    row_next = row + 13'sd1;
                    col_next = 13'sd0;
                  end
                  atte_pkg::K_TAB: state_next = S_TAB;
                  atte_pkg::K_BS: begin
                    if (col == 0) begin
                      if (row != 0) begin
                        row_next = row - 13'sd1;
                        col_next = cols_s - 13'sd1;
                      end
                    end else begin
                      col_next = col - 13'sd1;
                    end
                  end
                  atte_pkg::K_ESC: begin
                    pstate_next = P_ESC;
                    pcnt_next   = '0;
                    dcnt_next   = 2'd0;
                  end
                  default: begin
                    emit           = 1'b1;
                    e_item.cmd     = atte_pkg::CMD_PRINT;
                    e_item.glyph   = byte_c;
                    e_item.pos_col = col[7:0];
                    e_item.pos_row = row[7:0];
                    if (col + 13'sd1 >= cols_s) begin
                      col_next = 13'sd0;
                      row_next = row + 13'sd1;
                    end else begin
                      col_next = col + 13'sd1;
                    end
                  end
                endcase
              end
            endcase
            // Final byte of a control sequence.
            if (do_fin) begin
              pstate_next = P_IDLE;
              if (byte_c == "H" || byte_c == "f") begin
                if (p0 != 0 && p1 != 0) begin
                  row_next = signed'({3'b0, p0});
                  col_next = signed'({3'b0, p1});
                end else if (pcnt != PCW'(1)) begin
                  row_next = 13'sd0;
                  col_next = 13'sd0;
                end
              end else if (byte_c == "A" || byte_c == "B" || byte_c == "C"
                           || byte_c == "D") begin
                if (pcnt <= PCW'(1)) begin
                  if (byte_c == "A") begin
                    row_next = (row - cnt_s < 0) ? 13'sd0 : row - cnt_s;
                  end else if (byte_c == "B") begin
                    row_next = row + cnt_s;
                  end else if (byte_c == "C") begin
                    if (col + cnt_s >= cols_s) begin
                      col_next = col + cnt_s - cols_s;
                      row_next = row + 13'sd1;
                    end else begin
                      col_next = col + cnt_s;
                    end
                  end else begin
                    if (col - cnt_s < 0) begin
                      col_next = col - cnt_s + cols_s;
                      row_next = (row == 0) ? 13'sd0 : row - 13'sd1;
                    end else begin
                      col_next = col - cnt_s;
                    end
                  end
                end
              end else if (byte_c == "J") begin
                if (pcnt <= PCW'(1) && p0 == 10'd2) begin
                  emit       = 1'b1;
                  e_item.cmd = atte_pkg::CMD_CLEAR;
                  col_next   = 13'sd0;
                  row_next   = 13'sd0;
                  sub_next   = 1'b0;
                  state_next = S_J;
                end
              end else if (byte_c == "m") begin
                widx_next  = '0;
                sub_next   = 1'b0;
                state_next = S_WALK;
              end
            end
          end
        end
      end
      S_SER: begin
        if (can_emit) begin
          emit         = 1'b1;
          e_last       = 1'b1;
          e_item.cmd   = atte_pkg::CMD_SERIAL;
          e_item.glyph = chr;
          state_next   = S_IDLE;
        end
      end
      S_TAB: begin
        if (tab_col >= cols_s) begin
          col_next = tab_col - cols_s;
          row_next = row + 13'sd1;
        end else begin
          col_next = tab_col;
        end
        state_next = S_POST;
      end
      S_J: begin
        if (can_emit) begin
          emit = 1'b1;
          if (!sub) begin
            e_item.cmd = atte_pkg::CMD_BG;
            e_item.arg = atte_pkg::COLOR_BLACK;
            sub_next   = 1'b1;
          end else begin
            e_item.cmd = atte_pkg::CMD_FG;
            e_item.arg = atte_pkg::COLOR_WHITE;
            state_next = S_POST;
          end
        end
      end
      S_WALK: begin
        if (widx == pcnt) begin
          state_next = S_POST;
        end else if (can_emit) begin
          widx_next = widx + 1'b1;
          if (wval >= atte_pkg::BG_BASE) begin
            emit       = 1'b1;
            e_item.cmd = atte_pkg::CMD_BG;
            e_item.arg = {1'b0, wval - atte_pkg::BG_BASE};
          end else if (wval >= atte_pkg::FG_BASE) begin
            emit       = 1'b1;
            e_item.cmd = atte_pkg::CMD_FG;
            e_item.arg = {1'b0, wval - atte_pkg::FG_BASE};
          end else if (wval == 10'd0) begin
            // Reset attributes: black background, then white foreground.
            emit = 1'b1;
            if (!sub) begin
              e_item.cmd = atte_pkg::CMD_BG;
              e_item.arg = atte_pkg::COLOR_BLACK;
              sub_next   = 1'b1;
              widx_next  = widx;
            end else begin
              e_item.cmd = atte_pkg::CMD_FG;
              e_item.arg = atte_pkg::COLOR_WHITE;
              sub_next   = 1'b0;
            end
          end
        end
      end
      S_POST: begin
        if (can_emit) begin
          col_next = c1;
          emit     = 1'b1;
          if (r1 >= rows_s) begin
            e_item.cmd = atte_pkg::CMD_SCROLL;
            e_item.arg = 11'(r1 - rows_s + 13'sd1);
            row_next   = rows_s - 13'sd1;
            state_next = S_MOVE;
          end else begin
            row_next       = r1;
            e_last         = 1'b1;
            e_item.cmd     = atte_pkg::CMD_MOVE;
            e_item.pos_col = c1[7:0];
            e_item.pos_row = r1[7:0];
            state_next     = S_IDLE;
          end
        end
      end
      S_MOVE: begin
        if (can_emit) begin
          emit           = 1'b1;
          e_last         = 1'b1;
          e_item.cmd     = atte_pkg::CMD_MOVE;
          e_item.pos_col = col[7:0];
          e_item.pos_row = row[7:0];
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= st_wd;
    if (emit) begin
      out_item <= e_item;
      out_last <= e_last;
    end
    cur   <= cur_next;
    chr   <= chr_next;
    tab_q <= tab_q_next;
    widx  <= widx_next;
    sub   <= sub_next;
    if (rst) begin
      state     <= S_IDLE;
      pstate    <= P_IDLE;
      col       <= '0;
      row       <= '0;
      pcnt      <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      pstate <= pstate_next;
      col    <= col_next;
      row    <= row_next;
      pcnt   <= pcnt_next;
      dcnt   <= dcnt_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/ansi_text_terminal_engine.sv
// Sequence: with the back end idle, a byte's first command leaves through the output
// register and the closing cursor move comes from the post state; a tab passes through
// the tab state first, and a scroll is followed by the move state. Output stalls hold the sequence.
// The back-end sequencer takes one byte at a time and pops no new byte until its last
// command is issued; CSI J adds a background and a foreground command after the clear,
// and CSI m walks its parameters: a colour command each from 30 up, a pair per zero.
// Reset: synchronous, active high; cursor at 0,0, parser idle, queue empty, registers
// back to 80 columns, 25 rows, console mode.
module ansi_text_terminal_engine #(
  parameter int MAX_PARAMS = 16,
  parameter int TAB_STEP   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] cmd, [10:3] glyph, [18:11] pos_col, [26:19] pos_row, [37:27] arg, rest zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Configuration registers. Writes are always taken; an unknown index is dropped.
  atte_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_cols   <= 8'd80;
      cfg.num_rows   <= 8'd25;
      cfg.serial_out <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        atte_pkg::CFG_NUM_COLS:   cfg.num_cols   <= cfg_data;
        atte_pkg::CFG_NUM_ROWS:   cfg.num_rows   <= cfg_data;
        atte_pkg::CFG_SERIAL_OUT: cfg.serial_out <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The front end classifies each byte and holds it in a short queue, so the input side
  // keeps taking transactions, until the queue is full, while the back end walks a sequence.
  logic               q_valid, q_pop;
  atte_pkg::fe_item_t q_item;

  atte_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // The back end runs the parser and cursor, and emits every command through
  // a single output register.
  atte_pkg::out_item_t out_item;

  atte_back #(
    .MAX_PARAMS (MAX_PARAMS),
    .TAB_STEP   (TAB_STEP)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_item};

  // A cursor move always closes the commands of its byte.
  a_move_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == atte_pkg::CMD_MOVE |-> m_axis_tlast)
    else $error("cursor move not marked last");

  // A scroll is only issued for a real overflow.
  a_scroll_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] == atte_pkg::CMD_SCROLL
    |-> m_axis_tdata[37:27] != 11'd0)
    else $error("scroll with zero count");

  // Only defined command codes leave the block.
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
    else $error("undefined command code");

endmodule

### verif/testbench.sv
module testbench;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  glyph;
    logic [7:0]  pos_col;
    logic [7:0]  pos_row;
    logic [10:0] arg;
    logic        last;
  } term_cmd_t;

  localparam int PARAM_SLOTS = 16;
  localparam int TAB_WIDTH   = 4;
  localparam int STALL_LIMIT = 20000;

  // Parser states of the terminal predictor.
  typedef enum int {PS_IDLE, PS_ESC, PS_CSI, PS_NUM, PS_SEMI} parse_t;

  // Directed stimulus rows. Where chk is set, the byte's single result is typed in
  // and compared against the predictor's answer as well.
  typedef struct {
    logic [7:0] ch;
    bit         chk;
    term_cmd_t  want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  ansi_text_terminal_engine dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: the terminal's registers, cursor and escape parser.
  int        term_cols, term_rows;
  bit        term_serial;
  int        cur_row, cur_col;
  parse_t    pstate;
  int        pcount, dcount;
  int        pstore [PARAM_SLOTS];

  term_cmd_t pending_cmds[$];
  term_cmd_t byte_cmds[$];
  int        mismatches;
  int        idle_cycles;
  int        sent_bytes;
  bit        hold_recv;
  bit        send_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int cols_eff();
    return (term_cols == 0) ? 1 : term_cols;
  endfunction

  function automatic int rows_eff();
    return (term_rows == 0) ? 1 : term_rows;
  endfunction

  function automatic void push_cmd(logic [2:0] c, int g, int col, int row, int a);
    term_cmd_t t;
    if (byte_cmds.size() >= 32) return;
    t.cmd = c; t.glyph = g[7:0]; t.pos_col = col[7:0]; t.pos_row = row[7:0];
    t.arg = a[10:0]; t.last = 1'b0;
    byte_cmds.push_back(t);
  endfunction

  function automatic void tab_forward();
    cur_col = cur_col - (cur_col % TAB_WIDTH) + TAB_WIDTH;
    if (cur_col >= cols_eff()) begin
      cur_row++;
      cur_col -= cols_eff();
    end
  endfunction

  function automatic void open_param(int d);
    if (pcount < PARAM_SLOTS - 1) begin
      pstore[pcount] = d;
      pcount++;
      dcount = 1;
    end else begin
      dcount = 3;
    end
    pstate = PS_NUM;
  endfunction

  function automatic void csi_final(logic [7:0] c);
    int p0, p1, cnt, a;
    p0 = pstore[0];
    p1 = pstore[1];
    cnt = (p0 != 0) ? p0 : 1;
    pstate = PS_IDLE;
    if (c == "H" || c == "f") begin
      if (p0 != 0 && p1 != 0) begin
        cur_row = p0; cur_col = p1;
      end else if (pcount != 1) begin
        cur_row = 0; cur_col = 0;
      end
    end else if (c == "A" || c == "B" || c == "C" || c == "D") begin
      if (pcount > 1) return;
      if (c == "A") begin
        cur_row -= cnt;
        if (cur_row < 0) cur_row = 0;
      end else if (c == "B") begin
        cur_row += cnt;
      end else if (c == "C") begin
        cur_col += cnt;
        if (cur_col >= cols_eff()) begin
          cur_row++;
          cur_col -= cols_eff();
        end
      end else begin
        cur_col -= cnt;
        if (cur_col < 0) begin
          cur_col += cols_eff();
          cur_row--;
          if (cur_row < 0) cur_row = 0;
        end
      end
    end else if (c == "J") begin
      if (pcount > 1 || p0 != 2) return;
      push_cmd(atte_pkg::CMD_CLEAR, 0, 0, 0, 0);
      cur_col = 0; cur_row = 0;
      push_cmd(atte_pkg::CMD_BG, 0, 0, 0, atte_pkg::COLOR_BLACK);
      push_cmd(atte_pkg::CMD_FG, 0, 0, 0, atte_pkg::COLOR_WHITE);
    end else if (c == "m") begin
      for (int i = 0; i < pcount; i++) begin
        a = pstore[i];
        if (a >= 40) push_cmd(atte_pkg::CMD_BG, 0, 0, 0, a - 40);
        else if (a >= 30) push_cmd(atte_pkg::CMD_FG, 0, 0, 0, a - 30);
        else if (a == 0) begin
          push_cmd(atte_pkg::CMD_BG, 0, 0, 0, atte_pkg::COLOR_BLACK);
          push_cmd(atte_pkg::CMD_FG, 0, 0, 0, atte_pkg::COLOR_WHITE);
        end
      end
    end
  endfunction

  // Works out every command one byte causes, in order, and queues them.
  function automatic void predict_byte(logic [7:0] c);
    bit dig;
    dig = (c >= "0" && c <= "9");
    byte_cmds.delete();
    if (term_serial) begin
      if (c == atte_pkg::CH_LF) push_cmd(atte_pkg::CMD_SERIAL, atte_pkg::CH_CR, 0, 0, 0);
      push_cmd(atte_pkg::CMD_SERIAL, c, 0, 0, 0);
    end else begin
      case (pstate)
        PS_ESC: begin
          pstate = PS_IDLE;
          if (c == "D") cur_row++;
          else if (c == "M") begin
            if (cur_row > 0) cur_row--;
          end else if (c == "H") tab_forward();
          else if (c == "[") pstate = PS_CSI;
        end
        PS_CSI: begin
          if (dig) open_param(c - "0");
          else csi_final(c);
        end
        PS_NUM: begin
          if (c == ";") pstate = PS_SEMI;
          else if (dig) begin
            if (dcount < 3 && pcount > 0) begin
              pstore[pcount-1] = pstore[pcount-1] * 10 + (c - "0");
              dcount++;
            end
          end else csi_final(c);
        end
        PS_SEMI: begin
          if (dig) open_param(c - "0");
          else pstate = PS_IDLE;
        end
        default: begin
          pstate = PS_IDLE;
          if (c == atte_pkg::CH_LF || c == atte_pkg::CH_CR) begin
            cur_row++; cur_col = 0;
          end else if (c == atte_pkg::CH_TAB) tab_forward();
          else if (c == atte_pkg::CH_BS) begin
            cur_col--;
            if (cur_col < 0) begin
              if (cur_row == 0) cur_col = 0;
              else begin
                cur_row--;
                cur_col = cols_eff() - 1;
              end
            end
          end else if (c == atte_pkg::CH_ESC) begin
            pstate = PS_ESC;
            pcount = 0; dcount = 0;
            foreach (pstore[i]) pstore[i] = 0;
          end else begin
            push_cmd(atte_pkg::CMD_PRINT, c, cur_col, cur_row, 0);
            cur_col++;
            if (cur_col >= cols_eff()) begin
              cur_col = 0; cur_row++;
            end
          end
        end
      endcase
      if (cur_col < 0) cur_col = 0;
      if (cur_col > cols_eff() - 1) cur_col = cols_eff() - 1;
      if (cur_row < 0) cur_row = 0;
      if (cur_row >= rows_eff()) begin
        push_cmd(atte_pkg::CMD_SCROLL, 0, 0, 0, cur_row - rows_eff() + 1);
        cur_row = rows_eff() - 1;
      end
      push_cmd(atte_pkg::CMD_MOVE, 0, cur_col, cur_row, 0);
    end
    byte_cmds[byte_cmds.size()-1].last = 1'b1;
    foreach (byte_cmds[i]) pending_cmds.push_back(byte_cmds[i]);
  endfunction

  function automatic void note_mismatch(string what, term_cmd_t want, term_cmd_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"mismatch (%s): expected cmd=%0d glyph=%h col=%0d row=%0d arg=%0d last=%0b,",
                " got cmd=%0d glyph=%h col=%0d row=%0d arg=%0d last=%0b"},
               what, want.cmd, want.glyph, want.pos_col, want.pos_row, want.arg, want.last,
               got.cmd, got.glyph, got.pos_col, got.pos_row, got.arg, got.last);
  endfunction

  // Short gaps mostly, a long one now and then.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus a long hold-off requested by the sender process.
  initial begin
    int g;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_recv) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Monitor: every result transaction is compared with the oldest expectation.
  always @(posedge clk) begin
    term_cmd_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.cmd = m_axis_tdata[2:0];
      got.glyph = m_axis_tdata[10:3];
      got.pos_col = m_axis_tdata[18:11];
      got.pos_row = m_axis_tdata[26:19];
      got.arg = m_axis_tdata[37:27];
      got.last = m_axis_tlast;
      if (pending_cmds.size() == 0) begin
        want = '0;
        note_mismatch("unexpected", want, got);
      end else begin
        want = pending_cmds.pop_front();
        if (got !== want) note_mismatch("field", want, got);
      end
    end
  end

  // Watchdog: cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] c);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_bytes++;
    predict_byte(c);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == atte_pkg::CFG_NUM_COLS) term_cols = val;
    else if (idx == atte_pkg::CFG_NUM_ROWS) term_rows = val;
    else term_serial = val[0];
  endtask

  function automatic term_cmd_t mk(logic [2:0] c, int g, int col, int row, int a);
    term_cmd_t t;
    t.cmd = c; t.glyph = g[7:0]; t.pos_col = col[7:0]; t.pos_row = row[7:0];
    t.arg = a[10:0]; t.last = 1'b1;
    return t;
  endfunction

  // Random content for one piece of terminal traffic, random bytes and broken sequences included.
  task automatic send_random_chunk();
    int kind, n;
    logic [7:0] finals [10];
    finals = '{"H", "f", "A", "B", "C", "D", "J", "m", "K", "x"};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      2: send_byte(8'($urandom_range(0, 255)));
      3: begin
        case ($urandom_range(0, 4))
          0: send_byte(atte_pkg::CH_LF);
          1: send_byte(atte_pkg::CH_CR);
          2: send_byte(atte_pkg::CH_TAB);
          default: send_byte(atte_pkg::CH_BS);
        endcase
      end
      4: begin
        send_byte(atte_pkg::CH_ESC);
        case ($urandom_range(0, 3))
          0: send_byte("D");
          1: send_byte("M");
          2: send_byte("H");
          default: send_byte(8'($urandom_range(0, 255)));
        endcase
      end
      default: begin
        send_byte(atte_pkg::CH_ESC);
        send_byte("[");
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 3);
        for (int p = 0; p < n; p++) begin
          if (p > 0) send_byte(";");
          repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 5 : 2))
            send_byte(8'("0" + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(0, 255)));
        else if (kind == 9 && n > 0) send_byte("m");
        else send_byte(finals[$urandom_range(0, 9)]);
      end
    endcase
  endtask

  initial begin
    dir_row_t dir_rows[$];
    int snapshot;
    term_cmd_t want;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= atte_pkg::CFG_NUM_COLS;
    cfg_data      <= '0;
    hold_recv     = 1'b0;
    send_done     = 1'b0;
    mismatches    = 0;
    idle_cycles   = 0;
    sent_bytes    = 0;
    term_cols = 80; term_rows = 25; term_serial = 1'b0;
    cur_row = 0; cur_col = 0; pstate = PS_IDLE; pcount = 0; dcount = 0;
    foreach (pstore[i]) pstore[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: reset defaults, printing, control bytes, escapes, the CSI J and m
    // finals, digit overflow and the SGR walk.
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'hFF, 1'b0, '0});
    dir_rows.push_back('{atte_pkg::CH_BS, 1'b0, '0});
    dir_rows.push_back('{atte_pkg::CH_BS, 1'b1, mk(atte_pkg::CMD_MOVE, 0, 0, 0, 0)});
    dir_rows.push_back('{atte_pkg::CH_TAB, 1'b1, mk(atte_pkg::CMD_MOVE, 0, 4, 0, 0)});
    dir_rows.push_back('{atte_pkg::CH_LF, 1'b1, mk(atte_pkg::CMD_MOVE, 0, 0, 1, 0)});
    dir_rows.push_back('{atte_pkg::CH_BS, 1'b1, mk(atte_pkg::CMD_MOVE, 0, 79, 0, 0)});
    dir_rows.push_back('{atte_pkg::CH_ESC, 1'b1, mk(atte_pkg::CMD_MOVE, 0, 79, 0, 0)});
    dir_rows.push_back('{"D", 1'b1, mk(atte_pkg::CMD_MOVE, 0, 79, 1, 0)});
    dir_rows.push_back('{atte_pkg::CH_ESC, 1'b0, '0});
    dir_rows.push_back('{"[", 1'b0, '0});
    dir_rows.push_back('{"2", 1'b0, '0});
    dir_rows.push_back('{"J", 1'b0, '0});
    dir_rows.push_back('{atte_pkg::CH_ESC, 1'b0, '0});
    dir_rows.push_back('{"[", 1'b0, '0});
    dir_rows.push_back('{"0", 1'b0, '0});
    dir_rows.push_back('{";", 1'b0, '0});
    dir_rows.push_back('{"3", 1'b0, '0});
    dir_rows.push_back('{"7", 1'b0, '0});
    dir_rows.push_back('{";", 1'b0, '0});
    dir_rows.push_back('{"9", 1'b0, '0});
    dir_rows.push_back('{"9", 1'b0, '0});
    dir_rows.push_back('{"9", 1'b0, '0});
    dir_rows.push_back('{"9", 1'b0, '0});
    dir_rows.push_back('{"m", 1'b0, '0});
    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].ch);
      if (dir_rows[i].chk) begin
        want = byte_cmds[0];
        if (byte_cmds.size() != 1 || want !== dir_rows[i].want)
          note_mismatch("table", dir_rows[i].want, want);
      end
    end
    drain();

    // Random traffic in phases with different register settings, extremes included.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin
          write_reg(atte_pkg::CFG_NUM_COLS, 8'd1);
          write_reg(atte_pkg::CFG_NUM_ROWS, 8'd1);
        end
        1: begin
          write_reg(atte_pkg::CFG_NUM_COLS, 8'd255);
          write_reg(atte_pkg::CFG_NUM_ROWS, 8'd255);
        end
        2: write_reg(atte_pkg::CFG_SERIAL_OUT, 8'd1);
        3: begin
          write_reg(atte_pkg::CFG_SERIAL_OUT, 8'd0);
          write_reg(atte_pkg::CFG_NUM_COLS, 8'd7);
          write_reg(atte_pkg::CFG_NUM_ROWS, 8'd5);
        end
        4: begin
          write_reg(atte_pkg::CFG_NUM_COLS, 8'd0);
          write_reg(atte_pkg::CFG_NUM_ROWS, 8'd0);
        end
        default: begin
          write_reg(atte_pkg::CFG_NUM_COLS, 8'($urandom_range(1, 255)));
          write_reg(atte_pkg::CFG_NUM_ROWS, 8'($urandom_range(1, 255)));
        end
      endcase
      if (phase == 1) hold_recv = 1'b1;
      snapshot = sent_bytes;
      while (sent_bytes - snapshot < 56) send_random_chunk();
      drain();
    end
    send_done = 1'b1;

    if (pending_cmds.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### ansi_text_terminal_engine.f
sv/atte_pkg.sv
sv/atte_front.sv
sv/atte_back.sv
sv/ansi_text_terminal_engine.sv
verif/testbench.sv
